FILE: hdl/sse_pkg.sv
`default_nettype none
package sse_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } sse_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_DECIDE,
    ST_URD,
    ST_UWR,
    ST_DRD,
    ST_DWR
  } sse_state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDXM1,
    RD_IDXP1
  } sse_rdsel_t;

  typedef enum logic {
    WR_RD,
    WR_KEY
  } sse_wrsel_t;

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_ld_cnt;
    logic       idx_ld_pos;
    logic       pos_ld;
    logic       found_set;
    logic       rd_en;
    sse_rdsel_t rd_sel;
    logic       wr_en;
    sse_wrsel_t wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       finish;
    logic       res_success;
    logic       res_reject;
  } sse_cmd_t;

  typedef struct packed {
    logic    scan_end;
    logic    eq;
    logic    gt;
    logic    found;
    logic    full;
    logic    up_done;
    logic    dn_done;
    sse_op_t op;
  } sse_stat_t;

endpackage
`default_nettype wire

FILE: hdl/sse_datapath.sv
`default_nettype none
module sse_datapath
  import sse_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sse_cmd_t                 cmd,
  input  wire logic [1:0]               in_operation,
  input  wire logic signed [ELEM_W-1:0] in_element,
  output sse_stat_t                     stat,
  output logic                          out_valid,
  output logic                          out_success,
  output logic                          out_full_reject,
  output logic [CNT_W-1:0]              out_element_count,
  output logic                          out_is_empty
);

  logic signed [ELEM_W-1:0] mem [CAPACITY];

  logic [1:0]               op_r;
  logic signed [ELEM_W-1:0] key_r;
  logic signed [ELEM_W-1:0] rd_data_r;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         pos_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     found_r;
  logic                     out_valid_r;
  logic                     out_success_r;
  logic                     out_reject_r;
  logic [CNT_W-1:0]         out_count_r;
  logic [CNT_W-1:0]         rd_addr;
  logic [CNT_W-1:0]         wr_addr;
  logic signed [ELEM_W-1:0] wr_data;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDXM1: rd_addr = idx_r - CNT_W'(1);
      RD_IDXP1: rd_addr = idx_r + CNT_W'(1);
      default:  rd_addr = idx_r;
    endcase
    if (cmd.wr_sel == WR_KEY) begin
      wr_addr = pos_r;
      wr_data = key_r;
    end else begin
      wr_addr = idx_r;
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_ld_cnt) begin
      idx_nxt = cnt_r;
    end else if (cmd.idx_ld_pos) begin
      idx_nxt = pos_r;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - CNT_W'(1);
    end
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r    <= in_operation;
      key_r   <= in_element;
      found_r <= 1'b0;
    end else if (cmd.found_set) begin
      found_r <= 1'b1;
    end
    if (cmd.pos_ld) begin
      pos_r <= idx_r;
    end
    if (cmd.finish) begin
      out_success_r <= cmd.res_success;
      out_reject_r  <= cmd.res_reject;
      out_count_r   <= cnt_nxt;
    end
  end

  always_comb begin
    stat.scan_end = (idx_r == cnt_r);
    stat.eq       = (rd_data_r == key_r);
    stat.gt       = (rd_data_r > key_r);
    stat.found    = found_r;
    stat.full     = (cnt_r == CNT_W'(CAPACITY));
    stat.up_done  = (idx_r == pos_r);
    stat.dn_done  = ((idx_r + CNT_W'(1)) >= cnt_r);
    stat.op       = sse_op_t'(op_r);
  end

  assign out_valid         = out_valid_r;
  assign out_success       = out_success_r;
  assign out_full_reject   = out_reject_r;
  assign out_element_count = out_count_r;
  assign out_is_empty      = (out_count_r == '0);

endmodule
`default_nettype wire

FILE: hdl/sse_ctrl.sv
`default_nettype none
module sse_ctrl
  import sse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire sse_stat_t stat,
  output sse_cmd_t       cmd,
  output logic           busy
);

  sse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SRD;
        end
      end
      ST_SRD: begin
        if (stat.scan_end) begin
          cmd.pos_ld = 1'b1;
          state_nxt  = ST_DECIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = ST_SCMP;
        end
      end
      ST_SCMP: begin
        // Entries are ascending, so the first one not below the key ends the scan.
        if (stat.eq) begin
          cmd.found_set = 1'b1;
          cmd.pos_ld    = 1'b1;
          state_nxt     = ST_DECIDE;
        end else if (stat.gt) begin
          cmd.pos_ld = 1'b1;
          state_nxt  = ST_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SRD;
        end
      end
      ST_DECIDE: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.found || stat.full) begin
              cmd.finish     = 1'b1;
              cmd.res_reject = !stat.found;
              state_nxt      = ST_IDLE;
            end else begin
              cmd.idx_ld_cnt = 1'b1;
              state_nxt      = ST_URD;
            end
          end
          OP_REMOVE: begin
            if (stat.found) begin
              cmd.idx_ld_pos = 1'b1;
              state_nxt      = ST_DRD;
            end else begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
          OP_LOOKUP: begin
            cmd.finish      = 1'b1;
            cmd.res_success = stat.found;
            state_nxt       = ST_IDLE;
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        endcase
      end
      ST_URD: begin
        if (stat.up_done) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_sel      = WR_KEY;
          cmd.cnt_inc     = 1'b1;
          cmd.finish      = 1'b1;
          cmd.res_success = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDXM1;
          state_nxt  = ST_UWR;
        end
      end
      ST_UWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RD;
        cmd.idx_dec = 1'b1;
        state_nxt   = ST_URD;
      end
      ST_DRD: begin
        if (stat.dn_done) begin
          cmd.cnt_dec     = 1'b1;
          cmd.finish      = 1'b1;
          cmd.res_success = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDXP1;
          state_nxt  = ST_DWR;
        end
      end
      ST_DWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RD;
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_DRD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

FILE: hdl/sorted_set_engine.sv
// Operation: the scan reads and compares the entries in turn until the first one not below
// the key or the end of the store; a look up, refused insert or missed remove then strobes
// the result. An insert shifts the entries from that place on up by one, last first, and
// writes the key; a remove shifts the entries after it down by one. Throughput: one item at
// a time; busy drops in the strobe cycle, so the next transfer can be accepted in that cycle.
// Reset clears the count and the controller; no clearing pass. The receiver cannot stall.
`default_nettype none
module sorted_set_engine
  import sse_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_operation,
  input  wire logic signed [ELEM_W-1:0] in_element,
  output logic                          out_valid,
  output logic                          out_success,
  output logic                          out_full_reject,
  output logic [CNT_W-1:0]              out_element_count,
  output logic                          out_is_empty
);

  sse_cmd_t  cmd;
  sse_stat_t stat;

  sse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sse_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_element        (in_element),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_success       (out_success),
    .out_full_reject   (out_full_reject),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty)
  );

endmodule
`default_nettype wire

FILE: hdl/sse_checker.sv
`default_nettype none
module sse_checker
  import sse_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic             out_success,
  input wire logic             out_full_reject,
  input wire logic [CNT_W-1:0] out_element_count,
  input wire logic             out_is_empty
);

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_element_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_element_count <= CNT_W'(CAPACITY)))
    else $error("count above capacity");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_reject) |->
      (!out_success && out_element_count == CNT_W'(CAPACITY)))
    else $error("reject without a full store");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

endmodule

bind sorted_set_engine sse_checker u_sse_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_success       (out_success),
  .out_full_reject   (out_full_reject),
  .out_element_count (out_element_count),
  .out_is_empty      (out_is_empty)
);
`default_nettype wire
